### hdl/first_fit_line_allocator_defines.svh
// Assertion macros for the line allocator checks
`ifndef FIRST_FIT_LINE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_LINE_ALLOCATOR_DEFINES_SVH
// clocked check, off while reset is high
`define FFLA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check, live through reset
`define FFLA_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### hdl/ffla_pkg.sv
// Shared types and codes of the first-fit line allocator
`default_nettype none
package ffla_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OOM  = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  typedef struct packed {
    logic        command;
    logic [31:0] request_bytes;
    logic [31:0] release_address;
  } request_t;

  typedef struct packed {
    logic [31:0] payload_address;
    status_t     status;
  } result_t;

  typedef enum logic [1:0] {
    JOB_DONE  = 2'd0,
    JOB_ALLOC = 2'd1,
    JOB_FREE  = 2'd2
  } job_kind_t;

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_WALK, B_FIT, B_HDR, B_APPEND,
    B_FCHK, B_FREAD, B_MNEXT, B_MEVAL, B_FWR, B_DONE
  } back_state_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage
`default_nettype wire

### hdl/ffla_ram.sv
// Generic RAM, one write port, one read port with registered data
`default_nettype none
module ffla_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

### hdl/ffla_front.sv
// Front end: classifies a request and settles the trivial cases
`default_nettype none
module ffla_front #(
  parameter int HEAP_LINES = 4096,
  parameter int LINE_BYTES = 64
) (
  input  wire ffla_pkg::request_t                request,
  input  wire logic [32-$clog2(LINE_BYTES):0]    base_line,
  output ffla_pkg::job_kind_t                    kind,
  output ffla_pkg::status_t                      status,
  output logic [$clog2(HEAP_LINES)-1:0]          need,
  output logic [$clog2(HEAP_LINES)-1:0]          line
);
  localparam int LB_SHIFT = $clog2(LINE_BYTES);
  localparam int LN_W     = $clog2(HEAP_LINES);
  localparam int AL_W     = 32 - LB_SHIFT;
  localparam int BL_W     = AL_W + 1;

  logic [BL_W-1:0] need_full;
  logic [AL_W-1:0] a_line;
  logic [BL_W-1:0] h_full;
  logic            low_bad;
  logic            below;
  logic            far;

  assign need_full = BL_W'(request.request_bytes[31:LB_SHIFT])
                   + BL_W'(|request.request_bytes[LB_SHIFT-1:0]);
  assign a_line  = request.release_address[31:LB_SHIFT];
  assign low_bad = |request.release_address[LB_SHIFT-1:0];
  assign below   = BL_W'(a_line) <= base_line;
  assign h_full  = BL_W'(a_line) - base_line - BL_W'(1);
  assign far     = h_full >= BL_W'(HEAP_LINES);

  always_comb begin
    kind   = ffla_pkg::JOB_DONE;
    status = ffla_pkg::ST_OK;
    need   = need_full[LN_W-1:0];
    line   = h_full[LN_W-1:0];
    if (request.command == ffla_pkg::CMD_ALLOC) begin
      if (request.request_bytes == 32'd0) begin
        status = ffla_pkg::ST_ZERO;
      end else if (need_full >= BL_W'(HEAP_LINES)) begin
        status = ffla_pkg::ST_OOM;
      end else begin
        kind = ffla_pkg::JOB_ALLOC;
      end
    end else begin
      if (request.release_address == 32'd0) begin
        status = ffla_pkg::ST_OK;
      end else if (below || low_bad || far) begin
        status = ffla_pkg::ST_BAD;
      end else begin
        kind = ffla_pkg::JOB_FREE;
      end
    end
  end
endmodule
`default_nettype wire

### hdl/ffla_queue.sv
// Short job queue between front and back
`default_nettype none
module ffla_queue #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output logic      [WIDTH-1:0] head
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end
endmodule
`default_nettype wire

### hdl/ffla_back.sv
// Back end: header walk, split, append, free and merge over the block table
`default_nettype none
module ffla_back #(
  parameter int HEAP_LINES = 4096,
  parameter int LINE_BYTES = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             clear_start,
  input  wire logic [32-$clog2(LINE_BYTES):0]   base_line,
  input  wire logic                             job_empty,
  input  wire ffla_pkg::job_kind_t              job_kind,
  input  wire ffla_pkg::status_t                job_status,
  input  wire logic [$clog2(HEAP_LINES)-1:0]    job_need,
  input  wire logic [$clog2(HEAP_LINES)-1:0]    job_line,
  output logic                                  job_pop,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output ffla_pkg::result_t                     result,
  output ffla_pkg::back_status_t                stat
);
  localparam int LB_SHIFT = $clog2(LINE_BYTES);
  localparam int LN_W     = $clog2(HEAP_LINES);
  localparam int SZ_W     = LN_W;
  localparam int BRK_W    = LN_W + 1;
  localparam int AL_W     = 32 - LB_SHIFT;
  localparam int BL_W     = AL_W + 1;
  localparam int E_W      = SZ_W + 2;

  ffla_pkg::back_state_t state, state_next;
  logic [BRK_W-1:0] cur, cur_next;
  logic [SZ_W-1:0]  need_r, need_r_next;
  logic [SZ_W-1:0]  sz_r, sz_r_next;
  logic [LN_W-1:0]  nx_r, nx_r_next;
  logic [BRK_W-1:0] brk, brk_next;
  logic [LN_W-1:0]  clr_cnt, clr_cnt_next;
  ffla_pkg::result_t res, res_next;
  ffla_pkg::result_t result_next;
  logic              result_valid_next;

  logic            wr_en;
  logic [LN_W-1:0] wr_addr;
  logic [E_W-1:0]  wr_data;
  logic [LN_W-1:0] rd_addr;
  logic [E_W-1:0]  rd_data;

  logic             e_mark;
  logic             e_free;
  logic [SZ_W-1:0]  e_sz;
  logic [BL_W-1:0]  room;
  logic [BRK_W-1:0] cap;
  logic [BRK_W:0]   app_end;
  logic [BRK_W-1:0] nx_full;
  logic             out_free;

  ffla_ram #(.WIDTH(E_W), .DEPTH(HEAP_LINES)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  function automatic logic [31:0] payload_of(input logic [BRK_W-1:0] hdr,
                                             input logic [BL_W-1:0] base);
    logic [BL_W:0] pl;
    pl = (BL_W+1)'(base) + (BL_W+1)'(hdr) + (BL_W+1)'(1);
    return 32'({pl, {LB_SHIFT{1'b0}}});
  endfunction

  assign e_mark  = rd_data[SZ_W+1];
  assign e_free  = rd_data[SZ_W];
  assign e_sz    = rd_data[SZ_W-1:0];
  assign room    = {1'b1, {AL_W{1'b0}}} - base_line;
  assign cap     = (room < BL_W'(HEAP_LINES)) ? BRK_W'(room) : BRK_W'(HEAP_LINES);
  assign app_end = (BRK_W+1)'(brk) + (BRK_W+1)'(need_r) + (BRK_W+1)'(1);
  assign nx_full = cur + BRK_W'(sz_r) + BRK_W'(1);
  assign out_free = !result_valid || !result_stall;
  assign stat.clearing = state == ffla_pkg::B_CLEAR;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ffla_pkg::B_CLEAR;
      brk          <= '0;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      brk          <= brk_next;
      clr_cnt      <= clr_cnt_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    need_r <= need_r_next;
    sz_r   <= sz_r_next;
    nx_r   <= nx_r_next;
    res    <= res_next;
    result <= result_next;
  end

  always_comb begin
    state_next        = state;
    cur_next          = cur;
    need_r_next       = need_r;
    sz_r_next         = sz_r;
    nx_r_next         = nx_r;
    brk_next          = brk;
    clr_cnt_next      = clr_cnt;
    res_next          = res;
    result_next       = result;
    result_valid_next = result_valid && result_stall;
    job_pop           = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = cur[LN_W-1:0];
    wr_data           = '0;
    rd_addr           = cur[LN_W-1:0];

    case (state)
      ffla_pkg::B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        clr_cnt_next = clr_cnt + LN_W'(1);
        if (clr_cnt == LN_W'(HEAP_LINES - 1)) begin
          state_next = ffla_pkg::B_IDLE;
        end
      end
      ffla_pkg::B_IDLE: begin
        if (!job_empty) begin
          job_pop     = 1'b1;
          need_r_next = job_need;
          res_next.payload_address = 32'd0;
          res_next.status          = job_status;
          case (job_kind)
            ffla_pkg::JOB_ALLOC: begin
              cur_next   = '0;
              state_next = ffla_pkg::B_WALK;
            end
            ffla_pkg::JOB_FREE: begin
              cur_next   = BRK_W'(job_line);
              state_next = ffla_pkg::B_FCHK;
            end
            default: begin
              state_next = ffla_pkg::B_DONE;
            end
          endcase
        end
      end
      ffla_pkg::B_WALK: begin
        if (cur >= brk) begin
          state_next = ffla_pkg::B_APPEND;
        end else begin
          state_next = ffla_pkg::B_FIT;
        end
      end
      ffla_pkg::B_FIT: begin
        if (e_free && e_sz >= need_r) begin
          sz_r_next  = e_sz;
          state_next = ffla_pkg::B_HDR;
          if ((SZ_W+1)'(e_sz) >= (SZ_W+1)'(need_r) + (SZ_W+1)'(2)) begin
            wr_en      = 1'b1;
            wr_addr    = cur[LN_W-1:0] + need_r + LN_W'(1);
            wr_data    = {1'b1, 1'b1, e_sz - need_r - SZ_W'(1)};
            sz_r_next  = need_r;
          end
        end else begin
          cur_next   = cur + BRK_W'(e_sz) + BRK_W'(1);
          state_next = ffla_pkg::B_WALK;
        end
      end
      ffla_pkg::B_HDR: begin
        wr_en   = 1'b1;
        wr_data = {1'b1, 1'b0, sz_r};
        res_next.payload_address = payload_of(cur, base_line);
        res_next.status          = ffla_pkg::ST_OK;
        state_next = ffla_pkg::B_DONE;
      end
      ffla_pkg::B_APPEND: begin
        if (app_end > (BRK_W+1)'(cap)) begin
          res_next.payload_address = 32'd0;
          res_next.status          = ffla_pkg::ST_OOM;
        end else begin
          wr_en   = 1'b1;
          wr_addr = brk[LN_W-1:0];
          wr_data = {1'b1, 1'b0, need_r};
          brk_next = app_end[BRK_W-1:0];
          res_next.payload_address = payload_of(brk, base_line);
          res_next.status          = ffla_pkg::ST_OK;
        end
        state_next = ffla_pkg::B_DONE;
      end
      ffla_pkg::B_FCHK: begin
        if (cur >= brk) begin
          res_next.status = ffla_pkg::ST_BAD;
          state_next      = ffla_pkg::B_DONE;
        end else begin
          state_next = ffla_pkg::B_FREAD;
        end
      end
      ffla_pkg::B_FREAD: begin
        if (!e_mark) begin
          res_next.status = ffla_pkg::ST_BAD;
          state_next      = ffla_pkg::B_DONE;
        end else begin
          sz_r_next  = e_sz;
          state_next = ffla_pkg::B_MNEXT;
        end
      end
      ffla_pkg::B_MNEXT: begin
        rd_addr   = nx_full[LN_W-1:0];
        nx_r_next = nx_full[LN_W-1:0];
        if (nx_full >= brk) begin
          state_next = ffla_pkg::B_FWR;
        end else begin
          state_next = ffla_pkg::B_MEVAL;
        end
      end
      ffla_pkg::B_MEVAL: begin
        if (e_mark && e_free) begin
          sz_r_next  = sz_r + e_sz + SZ_W'(1);
          wr_en      = 1'b1;
          wr_addr    = nx_r;
          wr_data    = '0;
          state_next = ffla_pkg::B_MNEXT;
        end else begin
          state_next = ffla_pkg::B_FWR;
        end
      end
      ffla_pkg::B_FWR: begin
        wr_en      = 1'b1;
        wr_data    = {1'b1, 1'b1, sz_r};
        state_next = ffla_pkg::B_DONE;
      end
      ffla_pkg::B_DONE: begin
        if (out_free) begin
          result_next       = res;
          result_valid_next = 1'b1;
          state_next        = ffla_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = ffla_pkg::B_IDLE;
      end
    endcase

    if (clear_start) begin
      state_next   = ffla_pkg::B_CLEAR;
      clr_cnt_next = '0;
      brk_next     = '0;
    end
  end
endmodule
`default_nettype wire

### hdl/first_fit_line_allocator.sv
// In the back end an allocate walks the block headers in turn, and a free merges each free
// neighbor that follows the block.
// Throughput: one request at a time in the back end; two more wait in the job queue.
// Reset and every heap_base write run a clearing pass over the block table, during
// which no request is accepted.
// Top level of the first-fit line allocator
`default_nettype none
module first_fit_line_allocator #(
  parameter int HEAP_LINES = 4096,
  parameter int LINE_BYTES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               request_valid,
  output logic                    request_stall,
  input  wire ffla_pkg::request_t request,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output ffla_pkg::result_t       result,
  input  wire logic               heap_base_valid,
  output logic                    heap_base_ready,
  input  wire logic [31:0]        heap_base
);
  localparam int LB_SHIFT = $clog2(LINE_BYTES);
  localparam int LN_W     = $clog2(HEAP_LINES);
  localparam int BL_W     = 33 - LB_SHIFT;
  localparam int JOB_W    = 4 + 2 * LN_W;

  logic [BL_W-1:0]        base_line;
  logic [32:0]            base_round;
  logic                   cfg_write;
  ffla_pkg::job_kind_t    f_kind;
  ffla_pkg::status_t      f_status;
  logic [LN_W-1:0]        f_need;
  logic [LN_W-1:0]        f_line;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;
  logic [JOB_W-1:0]       q_head;
  ffla_pkg::back_status_t stat;

  assign heap_base_ready = 1'b1;
  assign cfg_write  = heap_base_valid && heap_base_ready;
  assign base_round = 33'(heap_base) + 33'(LINE_BYTES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_line <= '0;
    end else if (cfg_write) begin
      base_line <= base_round[32:LB_SHIFT];
    end
  end

  assign request_stall = q_full || stat.clearing;
  assign q_push        = request_valid && !request_stall;

  ffla_front #(.HEAP_LINES(HEAP_LINES), .LINE_BYTES(LINE_BYTES)) u_front (
    .request   (request),
    .base_line (base_line),
    .kind      (f_kind),
    .status    (f_status),
    .need      (f_need),
    .line      (f_line)
  );

  ffla_queue #(.WIDTH(JOB_W), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_kind, f_status, f_need, f_line}),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  ffla_back #(.HEAP_LINES(HEAP_LINES), .LINE_BYTES(LINE_BYTES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .clear_start  (cfg_write),
    .base_line    (base_line),
    .job_empty    (q_empty),
    .job_kind     (ffla_pkg::job_kind_t'(q_head[JOB_W-1 -: 2])),
    .job_status   (ffla_pkg::status_t'(q_head[JOB_W-3 -: 2])),
    .job_need     (q_head[2*LN_W-1:LN_W]),
    .job_line     (q_head[LN_W-1:0]),
    .job_pop      (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .stat         (stat)
  );
endmodule
`default_nettype wire

### hdl/ffla_checker.sv
// Port-level checks of the line allocator, bound to the top level
`default_nettype none
`include "first_fit_line_allocator_defines.svh"
module ffla_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              request_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire ffla_pkg::result_t result,
  input wire logic              heap_base_valid,
  input wire logic              heap_base_ready
);
  `FFLA_ASSERT(a_hold, clk, rst, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")
  `FFLA_ASSERT(a_null, clk, rst, result_valid && (result.status == ffla_pkg::ST_ZERO || result.status == ffla_pkg::ST_OOM || result.status == ffla_pkg::ST_BAD) |-> result.payload_address == 32'd0, "failed request carries an address")
  `FFLA_ASSERT(a_clear, clk, rst, heap_base_valid && heap_base_ready |=> request_stall, "request taken during clearing")
  `FFLA_ASSERT_ANY(a_reset, clk, rst |=> !result_valid, "result valid right after reset")
endmodule

bind first_fit_line_allocator ffla_checker u_ffla_checker (
  .clk             (clk),
  .rst             (rst),
  .request_stall   (request_stall),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .result          (result),
  .heap_base_valid (heap_base_valid),
  .heap_base_ready (heap_base_ready)
);
`default_nettype wire

### tb/sv/first_fit_line_allocator_checker.sv
// Predictor and scoreboard for the first-fit line allocator
`default_nettype none
module first_fit_line_allocator_checker
  import ffla_pkg::*;
#(
  parameter int HEAP_LINES = 4096,
  parameter int LINE_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        request_valid,
  input  wire logic        request_stall,
  input  wire request_t    request,
  input  wire logic        result_valid,
  input  wire logic        result_stall,
  input  wire result_t     result,
  input  wire logic        heap_base_valid,
  input  wire logic        heap_base_ready,
  input  wire logic [31:0] heap_base,
  output int               failures,
  output int               pending
);

  localparam longint unsigned ADDR_SPAN = 64'h1_0000_0000;

  int unsigned     blk_size [HEAP_LINES];
  bit              blk_free [HEAP_LINES];
  bit              hdr_mark [HEAP_LINES];
  longint unsigned brk_line;
  longint unsigned base_addr;
  result_t         expected_q[$];

  function automatic void empty_heap();
    foreach (blk_size[i]) begin
      blk_size[i] = 0;
      blk_free[i] = 0;
      hdr_mark[i] = 0;
    end
    brk_line = 0;
  endfunction

  function automatic logic [31:0] payload_addr(longint unsigned h);
    longint unsigned a;
    a = base_addr + (h + 1) * LINE_BYTES;
    return a[31:0];
  endfunction

  function automatic result_t allocate(logic [31:0] bytes);
    longint unsigned need, h, sz, s, cap;
    result_t r;
    r.payload_address = '0;
    r.status = ST_OK;
    if (bytes == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    need = ({32'd0, bytes} + LINE_BYTES - 1) / LINE_BYTES;
    h = 0;
    while (h < brk_line && h < HEAP_LINES) begin
      sz = blk_size[h];
      if (blk_free[h] && sz >= need) begin
        if (sz >= need + 2) begin
          s = h + 1 + need;
          if (s < HEAP_LINES) begin
            blk_size[s] = sz - need - 1;
            blk_free[s] = 1;
            hdr_mark[s] = 1;
            sz = need;
          end
        end
        blk_size[h] = sz;
        blk_free[h] = 0;
        r.payload_address = payload_addr(h);
        return r;
      end
      h += 1 + sz;
    end
    cap = (ADDR_SPAN - base_addr) / LINE_BYTES;
    if (cap > HEAP_LINES) cap = HEAP_LINES;
    if (brk_line + 1 + need > cap) begin
      r.status = ST_OOM;
      return r;
    end
    h = brk_line;
    blk_size[h] = need;
    blk_free[h] = 0;
    hdr_mark[h] = 1;
    brk_line = h + 1 + need;
    r.payload_address = payload_addr(h);
    return r;
  endfunction

  function automatic result_t release_block(logic [31:0] addr);
    longint unsigned a, off, h, nx;
    result_t r;
    r.payload_address = '0;
    r.status = ST_OK;
    a = {32'd0, addr};
    if (addr == 0) return r;
    if (a < base_addr + LINE_BYTES) begin
      r.status = ST_BAD;
      return r;
    end
    off = a - base_addr;
    if (off % LINE_BYTES != 0) begin
      r.status = ST_BAD;
      return r;
    end
    h = off / LINE_BYTES - 1;
    if (h >= brk_line || h >= HEAP_LINES || !hdr_mark[h]) begin
      r.status = ST_BAD;
      return r;
    end
    blk_free[h] = 1;
    forever begin
      nx = h + 1 + blk_size[h];
      if (nx >= brk_line || nx >= HEAP_LINES) break;
      if (!hdr_mark[nx] || !blk_free[nx]) break;
      blk_size[h] = blk_size[h] + 1 + blk_size[nx];
      hdr_mark[nx] = 0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      errs;
    errs = 0;
    if (rst) begin
      base_addr = 0;
      empty_heap();
      expected_q.delete();
      failures <= 0;
    end else begin
      if (heap_base_valid && heap_base_ready) begin
        base_addr = (({32'd0, heap_base} + LINE_BYTES - 1) / LINE_BYTES) * LINE_BYTES;
        empty_heap();
      end
      if (request_valid && !request_stall) begin
        if (request.command == CMD_ALLOC) expected_q.push_back(allocate(request.request_bytes));
        else expected_q.push_back(release_block(request.release_address));
      end
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result addr=%h status=%0d", result.payload_address, result.status);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (result.payload_address !== want.payload_address) begin
            $error("payload_address expected %h actual %h",
                   want.payload_address, result.payload_address);
            errs++;
          end
          if (result.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, result.status);
            errs++;
          end
        end
      end
      failures <= failures + errs;
    end
    pending <= expected_q.size();
  end

endmodule
`default_nettype wire

### tb/sv/first_fit_line_allocator_tb.sv
// Stimulus and verdict for the first-fit line allocator testbench
`default_nettype none
module first_fit_line_allocator_tb;
  import ffla_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        request_valid = 1'b0;
  logic        request_stall;
  request_t    request = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        heap_base_valid = 1'b0;
  logic        heap_base_ready;
  logic [31:0] heap_base = '0;
  int          failures;
  int          pending;

  int          send_idle = 0;
  int          stall_pct = 0;
  logic        hold_request = 1'b0;
  bit          hold_done;
  int          hold_left;
  logic [31:0] live_q[$];

  always #5 clk = ~clk;

  first_fit_line_allocator u_dut (
    .clk(clk), .rst(rst),
    .request_valid(request_valid), .request_stall(request_stall), .request(request),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .heap_base_valid(heap_base_valid), .heap_base_ready(heap_base_ready),
    .heap_base(heap_base)
  );

  first_fit_line_allocator_checker u_checker (
    .clk(clk), .rst(rst),
    .request_valid(request_valid), .request_stall(request_stall), .request(request),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .heap_base_valid(heap_base_valid), .heap_base_ready(heap_base_ready),
    .heap_base(heap_base), .failures(failures), .pending(pending)
  );

  // receiver: random stall plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left = 0;
      hold_done = 0;
    end else begin
      if (hold_request && !hold_done) begin
        hold_left = 400;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall && result.payload_address != 0)
      live_q.push_back(result.payload_address);
  end

  task automatic send(logic cmd, logic [31:0] bytes, logic [31:0] addr);
    while ($urandom_range(99) < send_idle) begin
      request_valid <= 1'b0;
      @(posedge clk);
    end
    request <= '{command: cmd, request_bytes: bytes, release_address: addr};
    request_valid <= 1'b1;
    do @(posedge clk); while (request_stall);
  endtask

  task automatic drain();
    request_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_base(logic [31:0] value);
    drain();
    heap_base <= value;
    heap_base_valid <= 1'b1;
    do @(posedge clk); while (!heap_base_ready);
    heap_base_valid <= 1'b0;
    live_q.delete();
  endtask

  task automatic random_request();
    int          pick;
    int          idx;
    logic [31:0] bytes;
    logic [31:0] addr;
    pick = $urandom_range(99);
    if (pick < 55) begin
      pick = $urandom_range(99);
      if (pick < 3) bytes = 0;
      else if (pick < 6) bytes = $urandom;
      else if (pick < 14) bytes = $urandom_range(1, 64 * 300);
      else bytes = $urandom_range(1, 512);
      send(CMD_ALLOC, bytes, $urandom);
    end else begin
      pick = $urandom_range(99);
      if (pick < 75 && live_q.size() != 0) begin
        idx = $urandom_range(live_q.size() - 1);
        addr = live_q[idx];
        if ($urandom_range(9) < 8) live_q.delete(idx);
      end else if (pick < 82) begin
        addr = 0;
      end else if (pick < 92 && live_q.size() != 0) begin
        addr = live_q[$urandom_range(live_q.size() - 1)] + $urandom_range(1, 200);
      end else begin
        addr = $urandom;
      end
      send(CMD_FREE, $urandom, addr);
    end
  endtask

  initial begin
    logic [31:0] bases[4];
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_base(32'h0000_1000);
    send(CMD_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send(CMD_ALLOC, 32'd1, 32'd0);
    send(CMD_ALLOC, 32'd64, 32'd0);
    send(CMD_ALLOC, 32'd65, 32'd0);
    send(CMD_ALLOC, 32'd320, 32'd0);
    send(CMD_ALLOC, 32'd1, 32'd0);
    send(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send(CMD_FREE, 32'hFFFF_FFFF, 32'h0000_1200);
    send(CMD_ALLOC, 32'd64, 32'd0);
    send(CMD_FREE, 32'd0, 32'h0000_10C0);
    send(CMD_FREE, 32'd0, 32'h0000_1040);
    send(CMD_FREE, 32'd0, 32'h0000_1140);
    send(CMD_FREE, 32'd0, 32'h0000_1040);
    send(CMD_FREE, 32'd0, 32'h0000_1041);
    send(CMD_FREE, 32'd0, 32'h0000_0FC0);
    send(CMD_FREE, 32'd0, 32'h0000_1000);
    send(CMD_FREE, 32'd0, 32'h0000_1180);
    send(CMD_FREE, 32'd0, 32'h0000_8000);
    send(CMD_FREE, 32'd0, 32'hFFFF_FFFF);
    send(CMD_FREE, 32'd0, 32'd0);
    write_base(32'hFFFF_FFC0);
    send(CMD_ALLOC, 32'd1, 32'd0);
    write_base(32'hFFFF_FFFF);
    send(CMD_ALLOC, 32'd1, 32'd0);
    send(CMD_ALLOC, 32'd0, 32'd0);
    send(CMD_FREE, 32'd0, 32'hFFFF_FFFF);

    bases[0] = 32'h0000_0000;
    bases[1] = 32'h0012_3457;
    bases[2] = $urandom & 32'h7FFF_FFFF;
    bases[3] = 32'hFFFC_0000;
    for (int ph = 0; ph < 4; ph++) begin
      write_base(bases[ph]);
      case (ph)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 83; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 83; end
        default: begin send_idle = 7; stall_pct = 7; end
      endcase
      for (int n = 0; n < 325; n++) begin
        if (ph == 0 && n == 40) hold_request <= 1'b1;
        random_request();
      end
    end

    drain();
    if (failures == 0 && pending == 0) begin
      $display("first_fit_line_allocator_tb: PASS");
    end else begin
      $display("first_fit_line_allocator_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #300000000;
    $display("first_fit_line_allocator_tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+hdl
hdl/ffla_pkg.sv
hdl/ffla_ram.sv
hdl/ffla_front.sv
hdl/ffla_queue.sv
hdl/ffla_back.sv
hdl/first_fit_line_allocator.sv
hdl/ffla_checker.sv
tb/sv/first_fit_line_allocator_checker.sv
tb/sv/first_fit_line_allocator_tb.sv
